// ===== rtl/kft_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the keyed find-or-insert table.
// No dependencies; every other file imports this package.
package kft_pkg;

	localparam int WORD_W   = 32;
	localparam int SLOT_W   = 6;
	localparam int STATUS_W = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_FAIL     = 2'd0,
		ST_UPDATED  = 2'd1,
		ST_INSERTED = 2'd2
	} kft_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_FINISH
	} kft_state_t;

	// Control from the sequencer to the entry store
	typedef struct packed {
		logic              rd_en;
		logic [SLOT_W-1:0] rd_addr;
		logic              wr_key;
		logic              wr_value;
		logic [SLOT_W-1:0] wr_addr;
	} kft_mem_ctrl_t;

endpackage

// ===== rtl/kft_if.sv =====
`timescale 1ns / 1ps
// Request and response channel interfaces of the keyed find-or-insert table.
// Depends on kft_pkg.
interface kft_req_if;
	import kft_pkg::*;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] key_first;
	logic [WORD_W-1:0] key_second;
	logic [WORD_W-1:0] attr_a;
	logic [WORD_W-1:0] attr_b;
	logic [WORD_W-1:0] new_value;
	logic              pool_granted;

	modport source (output valid, key_first, key_second, attr_a, attr_b, new_value,
		pool_granted, input ready);
	modport sink (input valid, key_first, key_second, attr_a, attr_b, new_value,
		pool_granted, output ready);
endinterface

interface kft_rsp_if;
	import kft_pkg::*;
	logic              valid;
	logic              ready;
	kft_status_t       status;
	logic [SLOT_W-1:0] slot;

	modport source (output valid, status, slot, input ready);
	modport sink (input valid, status, slot, output ready);
endinterface

// ===== rtl/kft_store.sv =====
`timescale 1ns / 1ps
// Entry store: key, attribute and value memories, one registered key read port.
// Depends on kft_pkg.
module kft_store #(
	parameter int CAPACITY = 20
) (
	input  logic                          clk,
	input  kft_pkg::kft_mem_ctrl_t        ctrl,
	input  logic [kft_pkg::WORD_W-1:0]    wr_key_first,
	input  logic [kft_pkg::WORD_W-1:0]    wr_key_second,
	input  logic [kft_pkg::WORD_W-1:0]    wr_attr_a,
	input  logic [kft_pkg::WORD_W-1:0]    wr_attr_b,
	input  logic [kft_pkg::WORD_W-1:0]    wr_value,
	output logic [kft_pkg::WORD_W-1:0]    rd_key_first,
	output logic [kft_pkg::WORD_W-1:0]    rd_key_second
);
	import kft_pkg::*;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic [WORD_W-1:0] key_first_mem  [CAPACITY];
	logic [WORD_W-1:0] key_second_mem [CAPACITY];
	logic [WORD_W-1:0] attr_a_mem     [CAPACITY];
	logic [WORD_W-1:0] attr_b_mem     [CAPACITY];
	logic [WORD_W-1:0] value_mem      [CAPACITY];

	logic [WORD_W-1:0] rd_key_first_q;
	logic [WORD_W-1:0] rd_key_second_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr_key) begin
			key_first_mem[ctrl.wr_addr[IDX_W-1:0]]  <= wr_key_first;
			key_second_mem[ctrl.wr_addr[IDX_W-1:0]] <= wr_key_second;
			attr_a_mem[ctrl.wr_addr[IDX_W-1:0]]     <= wr_attr_a;
			attr_b_mem[ctrl.wr_addr[IDX_W-1:0]]     <= wr_attr_b;
		end
		if (ctrl.wr_value) begin
			value_mem[ctrl.wr_addr[IDX_W-1:0]] <= wr_value;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_key_first_q  <= key_first_mem[ctrl.rd_addr[IDX_W-1:0]];
			rd_key_second_q <= key_second_mem[ctrl.rd_addr[IDX_W-1:0]];
		end
	end

	assign rd_key_first  = rd_key_first_q;
	assign rd_key_second = rd_key_second_q;

endmodule

// ===== rtl/kft_seq.sv =====
`timescale 1ns / 1ps
// Search sequencer: request latch, slot scan with the shared key comparator,
// hit/insert/fail decision, entry count and response register. Depends on kft_pkg.
module kft_seq #(
	parameter int CAPACITY = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [kft_pkg::WORD_W-1:0]    key_first,
	input  logic [kft_pkg::WORD_W-1:0]    key_second,
	input  logic [kft_pkg::WORD_W-1:0]    attr_a,
	input  logic [kft_pkg::WORD_W-1:0]    attr_b,
	input  logic [kft_pkg::WORD_W-1:0]    new_value,
	input  logic                          pool_granted,
	output logic                          out_valid,
	input  logic                          out_ready,
	output kft_pkg::kft_status_t          status,
	output logic [kft_pkg::SLOT_W-1:0]    slot,
	output kft_pkg::kft_mem_ctrl_t        mem_ctrl,
	output logic [kft_pkg::WORD_W-1:0]    wr_key_first,
	output logic [kft_pkg::WORD_W-1:0]    wr_key_second,
	output logic [kft_pkg::WORD_W-1:0]    wr_attr_a,
	output logic [kft_pkg::WORD_W-1:0]    wr_attr_b,
	output logic [kft_pkg::WORD_W-1:0]    wr_value,
	input  logic [kft_pkg::WORD_W-1:0]    rd_key_first,
	input  logic [kft_pkg::WORD_W-1:0]    rd_key_second
);
	import kft_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	kft_state_t state_q, state_d;

	logic [WORD_W-1:0] key_first_q, key_second_q, attr_a_q, attr_b_q, value_q;
	logic              granted_q;

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  cmp_idx_q;
	logic              cmp_valid_q;

	kft_status_t       res_status_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic              out_valid_q;
	kft_status_t       out_status_q;
	logic [SLOT_W-1:0] out_slot_q;

	logic              accept, issue, key_match, count_inc, res_load, out_load;
	kft_status_t       res_status_d;
	logic [SLOT_W-1:0] res_slot_d;

	assign accept    = in_valid && in_ready;
	assign key_match = (rd_key_first == key_first_q) && (rd_key_second == key_second_q);

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		issue        = 1'b0;
		count_inc    = 1'b0;
		res_load     = 1'b0;
		out_load     = 1'b0;
		res_status_d = ST_FAIL;
		res_slot_d   = '0;
		mem_ctrl     = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (cmp_valid_q && key_match) begin
					// hit: overwrite the value of the first matching slot
					mem_ctrl.wr_value = 1'b1;
					mem_ctrl.wr_addr  = SLOT_W'(cmp_idx_q);
					res_status_d      = ST_UPDATED;
					res_slot_d        = SLOT_W'(cmp_idx_q);
					res_load          = 1'b1;
					state_d           = S_FINISH;
				end else if (idx_q < count_q) begin
					issue            = 1'b1;
					mem_ctrl.rd_en   = 1'b1;
					mem_ctrl.rd_addr = SLOT_W'(idx_q);
				end else if (!cmp_valid_q) begin
					// scan exhausted without a match
					res_load = 1'b1;
					state_d  = S_FINISH;
					if (granted_q && (count_q < CAP_CNT)) begin
						mem_ctrl.wr_key   = 1'b1;
						mem_ctrl.wr_value = 1'b1;
						mem_ctrl.wr_addr  = SLOT_W'(count_q);
						res_status_d      = ST_INSERTED;
						res_slot_d        = SLOT_W'(count_q);
						count_inc         = 1'b1;
					end
				end
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			cmp_idx_q   <= '0;
			cmp_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			cmp_valid_q <= issue;
			cmp_idx_q   <= idx_q;
			if (count_inc) begin
				count_q <= count_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers: no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			key_first_q  <= key_first;
			key_second_q <= key_second;
			attr_a_q     <= attr_a;
			attr_b_q     <= attr_b;
			value_q      <= new_value;
			granted_q    <= pool_granted;
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_slot_q   <= res_slot_d;
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign slot          = out_slot_q;
	assign wr_key_first  = key_first_q;
	assign wr_key_second = key_second_q;
	assign wr_attr_a     = attr_a_q;
	assign wr_attr_b     = attr_b_q;
	assign wr_value      = value_q;

endmodule

// ===== rtl/keyed_find_or_insert_table_core.sv =====
`timescale 1ns / 1ps
// Keyed find-or-insert table. Each request scans the filled slots in order with
// one key comparator fed by a single registered read port of the key memory, one
// slot per cycle; a hit overwrites that slot's value, a miss with a pool grant and
// room appends a new entry, anything else fails with slot 0. The next request can
// be taken in the cycle after the response register is loaded. The request channel
// is not ready while a request is in progress; a finished response waits in its
// own register.
// Depends on kft_pkg, kft_if, kft_store and kft_seq.
module keyed_find_or_insert_table_core #(
	parameter int CAPACITY = 20
) (
	input logic       clk,
	input logic       arst_n,
	kft_req_if.sink   req,
	kft_rsp_if.source rsp
);
	import kft_pkg::*;

	kft_mem_ctrl_t     mem_ctrl;
	logic [WORD_W-1:0] wr_key_first, wr_key_second, wr_attr_a, wr_attr_b, wr_value;
	logic [WORD_W-1:0] rd_key_first, rd_key_second;

	kft_seq #(
		.CAPACITY(CAPACITY)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (req.valid),
		.in_ready     (req.ready),
		.key_first    (req.key_first),
		.key_second   (req.key_second),
		.attr_a       (req.attr_a),
		.attr_b       (req.attr_b),
		.new_value    (req.new_value),
		.pool_granted (req.pool_granted),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.status       (rsp.status),
		.slot         (rsp.slot),
		.mem_ctrl     (mem_ctrl),
		.wr_key_first (wr_key_first),
		.wr_key_second(wr_key_second),
		.wr_attr_a    (wr_attr_a),
		.wr_attr_b    (wr_attr_b),
		.wr_value     (wr_value),
		.rd_key_first (rd_key_first),
		.rd_key_second(rd_key_second)
	);

	kft_store #(
		.CAPACITY(CAPACITY)
	) u_store (
		.clk          (clk),
		.ctrl         (mem_ctrl),
		.wr_key_first (wr_key_first),
		.wr_key_second(wr_key_second),
		.wr_attr_a    (wr_attr_a),
		.wr_attr_b    (wr_attr_b),
		.wr_value     (wr_value),
		.rd_key_first (rd_key_first),
		.rd_key_second(rd_key_second)
	);

endmodule

// ===== rtl/kft_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the keyed find-or-insert table, bound to the top level.
// Depends on kft_pkg and keyed_find_or_insert_table_core.
module kft_checker #(
	parameter int CAPACITY = 20
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [kft_pkg::STATUS_W-1:0] status,
	input logic [kft_pkg::SLOT_W-1:0] slot
);
	import kft_pkg::*;

	// one request at a time: ready drops right after acceptance
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request channel ready right after an accepted request");

	a_fail_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FAIL) |-> slot == '0)
		else $error("failed response with non-zero slot");

	a_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_FAIL) |-> slot < SLOT_W'(CAPACITY))
		else $error("response slot beyond capacity");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot))
		else $error("stalled response changed or dropped");

endmodule

bind keyed_find_or_insert_table_core kft_checker #(
	.CAPACITY(CAPACITY)
) u_kft_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (req.valid),
	.in_ready (req.ready),
	.out_valid(rsp.valid),
	.out_ready(rsp.ready),
	.status   (rsp.status),
	.slot     (rsp.slot)
);
